/* rtl/core/dtb_pkg.sv */
// Shared widths, field offsets and operation codes for the deadline timer bank.
`default_nettype none

package dtb_pkg;

    localparam int OP_W   = 3;
    localparam int CH_W   = 6;
    localparam int DL_W   = 64;
    localparam int MASK_W = 32;

    // input item: tdata = {pad, deadline, channel}, tuser = op
    localparam int S_CH_LO   = 0;
    localparam int S_DL_LO   = S_CH_LO + CH_W;
    localparam int S_TDATA_W = ((S_DL_LO + DL_W + 7) / 8) * 8;

    // result item: tdata = {pad, wake, armed_deadline, due_mask, ok}
    localparam int M_OK_BIT  = 0;
    localparam int M_MASK_LO = 1;
    localparam int M_DL_LO   = M_MASK_LO + MASK_W;
    localparam int M_WAKE_BIT = M_DL_LO + DL_W;
    localparam int M_TDATA_W = ((M_WAKE_BIT + 1 + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_ARM    = 3'd0;
    localparam logic [OP_W-1:0] OP_DISARM = 3'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 3'd2;
    localparam logic [OP_W-1:0] OP_TAKE   = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

endpackage

`default_nettype wire

/* rtl/core/dtb_cmp.sv */
// Shared signed 64-bit time comparator (a <= b, two's complement).
`default_nettype none

module dtb_cmp
    import dtb_pkg::*;
(
    input  wire logic [DL_W-1:0] a,
    input  wire logic [DL_W-1:0] b,
    output logic                 le
);

    // flip the sign bits so an unsigned compare orders signed values
    logic [DL_W-1:0] a_biased;
    logic [DL_W-1:0] b_biased;

    always_comb begin
        a_biased = {~a[DL_W-1], a[DL_W-2:0]};
        b_biased = {~b[DL_W-1], b[DL_W-2:0]};
        le       = (a_biased <= b_biased);
    end

endmodule

`default_nettype wire

/* rtl/core/per_channel_deadline_timer_bank.sv */
// Top level of the per-channel one-shot deadline timer bank.
//
//  port group   dir  fields (lsb first)                              accepted when
//  s_*          in   tuser: op[2:0]; tdata: channel[5:0],            s_tvalid & s_tready
//                    deadline[69:6], zero pad[71:70]
//  m_*          out  tdata: ok[0], due_mask[32:1],                   m_tvalid & m_tready
//                    armed_deadline[96:33], wake[97], zero pad
//  cfg_*        in   cfg_wr_data: notify_enable                      cfg_wr_en
//
// Arm, disarm, take and unused ops go from EXEC straight to DONE; query passes
// through QRY (one registered memory read). A tick passes through SCAN: the
// single comparator walks the fire-time memory one channel per cycle, behind
// the read pipeline. s_tready returns in the same cycle the result appears.
// aresetn is synchronous, active low; it clears the clock, armed flags, the
// pending mask and notify_enable. Deadline memories are not cleared.
// s_tready is high only while idle; an item may be accepted while the previous
// result is still waiting on m_tready, and a finished item waits in DONE.
`default_nettype none

module per_channel_deadline_timer_bank
    import dtb_pkg::*;
#(
    parameter int CHANNELS = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // channel, deadline, pad
    input  wire logic [OP_W-1:0]      s_tuser,   // op
    // result items
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // ok, due_mask, armed_deadline, wake, pad
    // notify_enable register
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_wr_data
);

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW = $clog2(CHANNELS + 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EXEC = 6'b000010,
        ST_QRY  = 6'b000100,
        ST_SCAN = 6'b001000,
        ST_DONE = 6'b010000,
        ST_SPARE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // captured item
    logic [OP_W-1:0]     op_reg;
    logic [CH_W-1:0]     ch_reg;
    logic [DL_W-1:0]     dl_reg;

    // timer state
    logic [DL_W-1:0]     now_reg, now_next;
    logic [CHANNELS-1:0] armed_reg, armed_next;
    logic [MASK_W-1:0]   pending_reg, pending_next;
    logic                notify_reg;

    // tick scan
    logic [CW-1:0]       scan_cnt_reg, scan_cnt_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                any_reg, any_next;

    // result staging
    logic                res_ok_reg, res_ok_next;
    logic [DL_W-1:0]     res_dl_reg, res_dl_next;
    logic [MASK_W-1:0]   res_mask_reg, res_mask_next;

    // output register
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // memories
    logic [DL_W-1:0]     fire_mem [CHANNELS];
    logic [DL_W-1:0]     dl_mem   [CHANNELS];
    logic [DL_W-1:0]     fire_rd_reg;
    logic [DL_W-1:0]     dl_rd_reg;
    logic                mem_we;
    logic [DL_W-1:0]     fire_wr;
    logic [IW-1:0]       rd_addr;

    // decode
    logic [CH_W-1:0]     ch_m1;
    logic [IW-1:0]       ch_idx;
    logic                ch_valid;
    logic [DL_W-1:0]     now_inc;
    logic                scan_last;
    logic                out_free;
    logic                s_fire;

    // shared comparator
    logic [DL_W-1:0]     cmp_a;
    logic                cmp_le;

    dtb_cmp u_cmp (
        .a  (cmp_a),
        .b  (now_reg),
        .le (cmp_le)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        ch_m1     = ch_reg - CH_W'(1);
        ch_idx    = ch_m1[IW-1:0];
        ch_valid  = (ch_reg != '0) && (ch_reg <= CH_W'(CHANNELS));
        now_inc   = now_reg + DL_W'(1);
        scan_last = (scan_cnt_reg == CW'(CHANNELS));
        rd_addr   = (state_reg == ST_SCAN) ? scan_cnt_reg[IW-1:0] : ch_idx;
        cmp_a     = (state_reg == ST_SCAN) ? fire_rd_reg : dl_reg;
        // deadline already past (or now): fire on the next tick
        fire_wr   = cmp_le ? now_inc : dl_reg;
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        now_next      = now_reg;
        armed_next    = armed_reg;
        pending_next  = pending_reg;
        scan_cnt_next = scan_cnt_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        any_next      = any_reg;
        res_ok_next   = res_ok_reg;
        res_dl_next   = res_dl_reg;
        res_mask_next = res_mask_reg;
        mem_we        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_ok_next = 1'b0;
                res_dl_next = '0;
                any_next    = 1'b0;
                state_next  = ST_DONE;
                unique case (op_reg)
                    OP_ARM: begin
                        if (ch_valid) begin
                            mem_we              = 1'b1;
                            armed_next[ch_idx]  = 1'b1;
                            res_ok_next         = 1'b1;
                        end
                    end
                    OP_DISARM: begin
                        if (ch_valid) begin
                            armed_next[ch_idx] = 1'b0;
                        end
                    end
                    OP_TICK: begin
                        now_next      = now_inc;
                        scan_cnt_next = '0;
                        state_next    = ST_SCAN;
                    end
                    OP_TAKE: begin
                        res_mask_next = pending_reg;
                        pending_next  = '0;
                    end
                    OP_QUERY: begin
                        // dl_mem read is issued this cycle at ch_idx
                        state_next = ST_QRY;
                    end
                    default: begin
                    end
                endcase
            end
            ST_QRY: begin
                if (ch_valid && armed_reg[ch_idx]) begin
                    res_ok_next = 1'b1;
                    res_dl_next = dl_rd_reg;
                end
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                // fire_rd_reg holds the entry read for cmp_idx_reg last cycle
                if (cmp_vld_reg && armed_reg[cmp_idx_reg] && cmp_le) begin
                    armed_next[cmp_idx_reg]   = 1'b0;
                    pending_next[cmp_idx_reg] = 1'b1;
                    any_next                  = 1'b1;
                end
                if (scan_last) begin
                    state_next = ST_DONE;
                end else begin
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_cnt_reg[IW-1:0];
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            now_reg      <= '0;
            armed_reg    <= '0;
            pending_reg  <= '0;
            notify_reg   <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            now_reg     <= now_next;
            armed_reg   <= armed_next;
            pending_reg <= pending_next;
            cmp_vld_reg <= cmp_vld_next;
            if (cfg_wr_en) begin
                notify_reg <= cfg_wr_data;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg <= s_tuser;
            ch_reg <= s_tdata[S_CH_LO +: CH_W];
            dl_reg <= s_tdata[S_DL_LO +: DL_W];
        end
        scan_cnt_reg <= scan_cnt_next;
        cmp_idx_reg  <= cmp_idx_next;
        any_reg      <= any_next;
        res_ok_reg   <= res_ok_next;
        res_dl_reg   <= res_dl_next;
        res_mask_reg <= res_mask_next;
        // packed msb first: pad, wake, armed_deadline, due_mask, ok
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= {{(M_TDATA_W - M_WAKE_BIT - 1){1'b0}},
                            (op_reg == OP_TICK) && any_reg && notify_reg,
                            res_dl_reg,
                            (op_reg == OP_TAKE) ? res_mask_reg : pending_reg,
                            res_ok_reg};
        end
    end

    // deadline and fire-time memories, one write and one registered read port each
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            fire_mem[ch_idx] <= fire_wr;
            dl_mem[ch_idx]   <= dl_reg;
        end
        fire_rd_reg <= fire_mem[rd_addr];
        dl_rd_reg   <= dl_mem[rd_addr];
    end

    // an accepted item always starts execution on the next cycle
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg == ST_EXEC)
        else $error("accepted item did not start execution");

    // take leaves the pending mask empty
    a_take_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && op_reg == OP_TAKE) |=> pending_reg == '0)
        else $error("pending mask not cleared by take");

    // scan counter never runs past the channel count
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> scan_cnt_reg <= CW'(CHANNELS))
        else $error("scan counter out of range");

    // a result only appears after the sequencer finished an item
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside DONE");

endmodule

`default_nettype wire

/* dv/dtb_reply_checker.sv */
// Result checker for the deadline timer bank: predicts each reply and compares it.
module dtb_reply_checker
    import dtb_pkg::*;
#(
    parameter int CHANNELS = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [OP_W-1:0]      s_tuser,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_wr_data,
    output int                        fail_count,
    output int                        replies_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              ok;
        logic [MASK_W-1:0] due_mask;
        logic [DL_W-1:0]   armed_dl;
        logic              wake;
    } timer_reply_t;

    // shadow of the timer bank
    logic [DL_W-1:0]     now_ms;
    logic [CHANNELS-1:0] armed;
    logic [DL_W-1:0]     deadline_mem [CHANNELS];
    logic [DL_W-1:0]     fire_mem [CHANNELS];
    logic [MASK_W-1:0]   due_bits;
    logic                notify_en;

    timer_reply_t expected_replies[$];

    initial begin
        fail_count   = 0;
        replies_owed = 0;
    end

    function automatic timer_reply_t predict_timer_op(input logic [OP_W-1:0] op,
                                                      input logic [CH_W-1:0] ch,
                                                      input logic [DL_W-1:0] dl);
        timer_reply_t r;
        int           slot;
        logic         in_range;
        logic         any_due;
        r        = '0;
        slot     = int'(ch) - 1;
        in_range = (ch >= 1) && (int'(ch) <= CHANNELS);
        any_due  = 1'b0;
        case (op)
            OP_ARM: begin
                if (in_range) begin
                    deadline_mem[slot] = dl;
                    // a deadline already reached fires on the next tick
                    fire_mem[slot] = ($signed(dl) <= $signed(now_ms)) ? now_ms + 64'd1 : dl;
                    armed[slot]    = 1'b1;
                    r.ok           = 1'b1;
                end
            end
            OP_DISARM: begin
                if (in_range)
                    armed[slot] = 1'b0;
            end
            OP_TICK: begin
                now_ms = now_ms + 64'd1;
                for (int s = 0; s < CHANNELS; s++) begin
                    if (armed[s] && $signed(fire_mem[s]) <= $signed(now_ms)) begin
                        armed[s]    = 1'b0;
                        due_bits[s] = 1'b1;
                        any_due     = 1'b1;
                    end
                end
                r.wake = any_due & notify_en;
            end
            OP_TAKE: begin
                r.due_mask = due_bits;
                due_bits   = '0;
            end
            OP_QUERY: begin
                if (in_range && armed[slot]) begin
                    r.ok       = 1'b1;
                    r.armed_dl = deadline_mem[slot];
                end
            end
            default: ;
        endcase
        if (op != OP_TAKE)
            r.due_mask = due_bits;
        return r;
    endfunction

    task automatic note_miss(input string what, input logic [DL_W-1:0] want,
                             input logic [DL_W-1:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endtask

    always @(posedge aclk) begin
        timer_reply_t want;
        timer_reply_t got;
        if (!aresetn) begin
            now_ms    = '0;
            armed     = '0;
            due_bits  = '0;
            notify_en = 1'b0;
            expected_replies.delete();
        end else begin
            if (cfg_wr_en)
                notify_en = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                got.ok       = m_tdata[M_OK_BIT];
                got.due_mask = m_tdata[M_MASK_LO +: MASK_W];
                got.armed_dl = m_tdata[M_DL_LO +: DL_W];
                got.wake     = m_tdata[M_WAKE_BIT];
                if (expected_replies.size() == 0) begin
                    note_miss("unrequested item", '0, got.armed_dl);
                end else begin
                    want = expected_replies.pop_front();
                    if (got.ok !== want.ok)
                        note_miss("ok", 64'(want.ok), 64'(got.ok));
                    if (got.due_mask !== want.due_mask)
                        note_miss("due_mask", 64'(want.due_mask), 64'(got.due_mask));
                    if (got.armed_dl !== want.armed_dl)
                        note_miss("armed_deadline", want.armed_dl, got.armed_dl);
                    if (got.wake !== want.wake)
                        note_miss("wake", 64'(want.wake), 64'(got.wake));
                end
            end
            if (s_tvalid && s_tready)
                expected_replies.push_back(predict_timer_op(s_tuser,
                                                            s_tdata[S_CH_LO +: CH_W],
                                                            s_tdata[S_DL_LO +: DL_W]));
        end
        replies_owed <= expected_replies.size();
    end

endmodule

/* dv/tb.sv */
// Stimulus, clock, reset and verdict for the deadline timer bank testbench.
module tb;
    import dtb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_CH        = 32;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SEG_ITEMS   = 300;
    localparam int SEGMENTS    = 6;
    // op codes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
    localparam logic [DL_W-1:0] DL_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [DL_W-1:0] DL_MIN = 64'h8000_0000_0000_0000;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [OP_W-1:0]      s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en   = 1'b0;
    logic                 cfg_wr_data = 1'b0;

    int fail_count;
    int replies_owed;

    // idle percentages per side; 0 means never idle
    int tx_idle_pct = 30;
    int rx_idle_pct = 51;
    int tx_calm     = 0;
    int rx_calm     = 0;
    int cycles      = 0;

    // ticks issued so far; keeps random deadlines near the bank's clock
    logic [DL_W-1:0] ticks_sent = '0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    per_channel_deadline_timer_bank #(
        .CHANNELS(N_CH)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    dtb_reply_checker #(
        .CHANNELS(N_CH)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .replies_owed(replies_owed)
    );

    // Watchdog: a hung handshake or a lost reply ends the run here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("per_channel_deadline_timer_bank verification failed");
            $finish;
        end
    end

    // Result-side backpressure. Occasional calm stretches keep m_tready high
    // so back-to-back results also get exercised while stalls are enabled.
    always @(posedge aclk) begin
        if (rx_calm > 0) begin
            rx_calm  <= rx_calm - 1;
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 99) < 2) begin
            rx_calm  <= $urandom_range(10, 40);
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Send one item and return at the edge where it is accepted. s_tvalid
    // stays high into the next call unless that call decides to idle first.
    task automatic push_op(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                           input logic [DL_W-1:0] dl);
        if (tx_calm != 0) begin
            tx_calm--;
        end else if ($urandom_range(0, 99) < 2) begin
            tx_calm = $urandom_range(10, 40);
        end else begin
            while ($urandom_range(0, 99) < tx_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - CH_W - DL_W){1'b0}}, dl, ch};
        do @(posedge aclk); while (!s_tready);
        if (op == OP_TICK)
            ticks_sent = ticks_sent + 64'd1;
    endtask

    // Stop sending and wait until every reply is back. Every item yields a
    // reply, so an extra wait after that covers the block's settle time.
    task automatic drain;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (replies_owed != 0);
        repeat (N_CH + 8) @(posedge aclk);
    endtask

    // notify_enable write; only issued with the bank idle
    task automatic write_notify(input logic val);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [DL_W-1:0] pick_deadline();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)                      // close to the clock: fires soon or is late
            return ticks_sent + 64'($urandom_range(0, 40)) - 64'd8;
        else if (pick < 75)
            return {$urandom, $urandom};
        else if (pick < 85)
            case ($urandom_range(0, 3))
                0:       return DL_MAX;
                1:       return DL_MIN;
                2:       return '0;
                default: return '1;
            endcase
        else
            return ticks_sent + {32'd0, $urandom};
    endfunction

    function automatic logic [CH_W-1:0] pick_channel();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return CH_W'($urandom_range(1, N_CH));
        else if (pick < 90)
            return '0;
        else
            return CH_W'($urandom_range(N_CH + 1, 63));
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)      return OP_ARM;
        else if (pick < 40) return OP_DISARM;
        else if (pick < 70) return OP_TICK;
        else if (pick < 80) return OP_TAKE;
        else if (pick < 95) return OP_QUERY;
        else                return OP_SPARE_FIRST + OP_W'($urandom_range(0, 2));
    endfunction

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_notify(1'b1);

        // Directed: late and early deadlines, refused channels, extremes,
        // re-arm, query of armed/unarmed, disarm of a due channel, spare ops.
        push_op(OP_ARM,    6'd1,  '0);          // late: fires on next tick
        push_op(OP_ARM,    6'd32, DL_MIN);      // most negative deadline
        push_op(OP_ARM,    6'd0,  DL_MAX);      // channel 0 refused
        push_op(OP_ARM,    6'd33, 64'd5);       // just past the last channel
        push_op(OP_ARM,    6'd63, DL_MAX);      // top channel code refused
        push_op(OP_ARM,    6'd2,  DL_MAX);      // never fires
        push_op(OP_QUERY,  6'd1,  '0);
        push_op(OP_QUERY,  6'd3,  '0);          // never armed
        push_op(OP_QUERY,  6'd0,  '0);
        push_op(OP_TICK,   6'd0,  '0);          // channels 1 and 32 due, wake
        push_op(OP_QUERY,  6'd2,  '0);
        push_op(OP_TAKE,   6'd0,  '0);
        push_op(OP_TAKE,   6'd0,  '0);          // empty after clear
        push_op(OP_ARM,    6'd5,  64'd3);
        push_op(OP_ARM,    6'd5,  '1);          // re-arm with -1, now late
        push_op(OP_QUERY,  6'd5,  '0);
        push_op(OP_TICK,   6'd0,  '0);
        push_op(OP_DISARM, 6'd5,  '0);          // pending bit stays set
        push_op(OP_DISARM, 6'd0,  '0);
        push_op(OP_DISARM, 6'd40, '0);
        push_op(OP_SPARE_FIRST,        6'd1, DL_MAX);
        push_op(OP_SPARE_FIRST + 3'd1, 6'd2, '0);
        push_op(OP_SPARE_LAST,         6'd3, DL_MIN);
        push_op(OP_DISARM, 6'd2,  '0);
        push_op(OP_TAKE,   6'd0,  '0);

        // Random: two segments per idle mode, notify toggled at each boundary.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain();
            case (seg / 2)
                0: begin
                    tx_idle_pct <= 30;
                    rx_idle_pct <= 51;
                end
                1: begin
                    tx_idle_pct <= 51;
                    rx_idle_pct <= 30;
                end
                default: begin
                    tx_idle_pct <= 0;
                    rx_idle_pct <= 0;
                end
            endcase
            write_notify(seg % 2 == 1);
            for (int n = 0; n < SEG_ITEMS; n++)
                push_op(pick_op(), pick_channel(), pick_deadline());
        end

        drain();
        if (fail_count == 0)
            $display("per_channel_deadline_timer_bank verification clean");
        else
            $display("per_channel_deadline_timer_bank verification failed");
        $finish;
    end

endmodule
